// ----- src/gtet_pkg.sv -----
// shared types and constants of the grid tile event throttle
package gtet_pkg;

   localparam int POS_W      = 12;
   localparam int TIME_W     = 48;
   localparam int HOLD_W     = 32;
   localparam int SIZE_W     = 12;
   localparam int DIM_W      = 4;
   localparam int ACTIVE_W   = 7;
   localparam int TILE_OUT_W = 6;
   // largest tile number is 14 + 14 * 15, so eight bits cover every grid_dim
   localparam int TILE_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = POS_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_SIZE    = 2'd0,
      CSR_GRID_DIM     = 2'd1,
      CSR_ACTIVE_TILES = 2'd2,
      CSR_HOLDOFF_MS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   tile_size;
      logic [DIM_W-1:0]    grid_dim;
      logic [ACTIVE_W-1:0] active_tiles;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [TILE_W-1:0] tile;
      logic              bad;
   } job_type;

   typedef struct packed {
      logic [TILE_OUT_W-1:0] tile_index;
      logic                  log_event;
      logic                  out_of_range;
   } result_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_LOOKUP,
      BACK_DECIDE
   } back_state_type;

endpackage

// ----- src/gtet_fifo.sv -----
// small first-in first-out queue between pipeline parts
module gtet_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- src/gtet_front.sv -----
// front part: takes a request, divides the coordinates and classifies the tile
module gtet_front #(
   parameter int MAX_TILES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [gtet_pkg::POS_W-1:0]     pos_x,
   input  logic [gtet_pkg::POS_W-1:0]     pos_y,
   input  logic [gtet_pkg::TIME_W-1:0]    now_ms,
   input  gtet_pkg::cfg_type              cfg,
   output logic                           job_push,
   input  logic                           job_full,
   output gtet_pkg::job_type              job
);

   import gtet_pkg::*;

   front_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]      x_quo_ff, x_quo_in;
   logic [POS_W-1:0]      x_rem_ff, x_rem_in;
   logic [POS_W-1:0]      y_quo_ff, y_quo_in;
   logic [POS_W-1:0]      y_rem_ff, y_rem_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [2*POS_W-1:0]    x_step;
   logic [2*POS_W-1:0]    y_step;
   logic [TILE_W-1:0]     tile;
   logic                  bad;

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   function automatic logic [2*POS_W-1:0] div_step(input logic [POS_W-1:0] rem,
                                                   input logic [POS_W-1:0] quo,
                                                   input logic [POS_W-1:0] dvs);
      logic [POS_W:0] trial;
      logic [POS_W:0] diff;
      trial = {rem, quo[POS_W-1]};
      diff  = trial - {1'b0, dvs};
      if (!diff[POS_W]) begin
         return {diff[POS_W-1:0], quo[POS_W-2:0], 1'b1};
      end else begin
         return {trial[POS_W-1:0], quo[POS_W-2:0], 1'b0};
      end
   endfunction

   assign x_step = div_step(x_rem_ff, x_quo_ff, cfg.tile_size);
   assign y_step = div_step(y_rem_ff, y_quo_ff, cfg.tile_size);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (push) state_in = FRONT_DIVIDE;
         end
         FRONT_DIVIDE: begin
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            if (!job_full) state_in = FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      full     = 1'b1;
      job_push = 1'b0;
      unique case (state_ff)
         FRONT_IDLE:   full = 1'b0;
         FRONT_DIVIDE: full = 1'b1;
         FRONT_PUSH:   job_push = 1'b1;
         default:      full = 1'b1;
      endcase
   end

   // divider datapath
   always_comb begin
      cnt_in   = cnt_ff;
      x_quo_in = x_quo_ff;
      x_rem_in = x_rem_ff;
      y_quo_in = y_quo_ff;
      y_rem_in = y_rem_ff;
      now_in   = now_ff;
      if (state_ff == FRONT_IDLE && push) begin
         cnt_in   = '0;
         x_quo_in = pos_x;
         x_rem_in = '0;
         y_quo_in = pos_y;
         y_rem_in = '0;
         now_in   = now_ms;
      end else if (state_ff == FRONT_DIVIDE) begin
         cnt_in   = cnt_ff + 1'b1;
         x_rem_in = x_step[2*POS_W-1:POS_W];
         x_quo_in = x_step[POS_W-1:0];
         y_rem_in = y_step[2*POS_W-1:POS_W];
         y_quo_in = y_step[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      x_quo_ff <= x_quo_in;
      x_rem_ff <= x_rem_in;
      y_quo_ff <= y_quo_in;
      y_rem_ff <= y_rem_in;
      now_ff   <= now_in;
   end

   // tile number and range checks on the quotients
   always_comb begin
      tile = TILE_W'(x_quo_ff[DIM_W-1:0]) +
             TILE_W'(y_quo_ff[DIM_W-1:0]) * TILE_W'(cfg.grid_dim);
      bad  = (cfg.tile_size == '0) || (cfg.grid_dim == '0) ||
             (x_quo_ff >= POS_W'(cfg.grid_dim)) ||
             (y_quo_ff >= POS_W'(cfg.grid_dim)) ||
             (tile >= TILE_W'(cfg.active_tiles)) ||
             ({1'b0, tile} >= (TILE_W + 1)'(MAX_TILES));
   end

   assign job.now_ms = now_ff;
   assign job.tile   = bad ? '0 : tile;
   assign job.bad    = bad;

endmodule

// ----- src/gtet_back.sv -----
// back part: per-tile last-log table, holdoff check and result forming
module gtet_back #(
   parameter int MAX_TILES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   output logic                          job_pop,
   input  gtet_pkg::job_type             job,
   input  logic [gtet_pkg::HOLD_W-1:0]   holdoff_ms,
   output logic                          result_push,
   input  logic                          result_full,
   output gtet_pkg::result_type          result
);

   import gtet_pkg::*;

   localparam int TIDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

   back_state_type      state_ff, state_in;
   job_type             item_ff, item_in;
   logic [TIME_W-1:0]   last_mem [MAX_TILES];
   logic [MAX_TILES-1:0] written_ff;
   logic [TIME_W-1:0]   rd_data_ff;
   logic                rd_hit_ff;
   logic [TIDX_W-1:0]   addr;
   logic [TIME_W-1:0]   last_ms;
   logic [TIME_W:0]     due_ms;
   logic                log_now;
   logic                wr_en;

   assign addr = item_ff.tile[TIDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) state_in = BACK_LOOKUP;
         end
         BACK_LOOKUP: state_in = BACK_DECIDE;
         BACK_DECIDE: begin
            if (!result_full) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop     = 1'b0;
      result_push = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   job_pop = !job_empty;
         BACK_LOOKUP: job_pop = 1'b0;
         BACK_DECIDE: result_push = 1'b1;
         default:     job_pop = 1'b0;
      endcase
   end

   always_comb begin
      item_in = item_ff;
      if (state_ff == BACK_IDLE && !job_empty) item_in = job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // holdoff check: entries never written read as zero
   always_comb begin
      last_ms = rd_hit_ff ? rd_data_ff : '0;
      due_ms  = {1'b0, last_ms} + (TIME_W + 1)'(holdoff_ms);
      log_now = !item_ff.bad && (due_ms <= {1'b0, item_ff.now_ms});
      wr_en   = (state_ff == BACK_DECIDE) && !result_full && log_now;
   end

   // written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[addr] <= 1'b1;
      end
   end

   // last-log table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_mem[addr] <= item_ff.now_ms;
      end
      if (state_ff == BACK_LOOKUP) begin
         rd_data_ff <= last_mem[addr];
         rd_hit_ff  <= written_ff[addr];
      end
   end

   assign result.tile_index   = item_ff.tile[TILE_OUT_W-1:0];
   assign result.log_event    = log_now;
   assign result.out_of_range = item_ff.bad;

endmodule

// ----- src/grid_tile_event_throttle.sv -----
// top level of the grid tile event throttle
//
//   channel   ports                                  handshake
//   request   req_pos_x, req_pos_y, req_now_ms       req_push / req_full
//   response  rsp_tile_index, rsp_log_event,         rsp_pop / rsp_empty
//             rsp_out_of_range
//   config    csr_index, csr_wdata                   csr_we, no wait
//
// the front takes one request at a time: it loads it, runs twelve radix-2 steps of the x
// and y dividers side by side, then hands the classified request to the back, waiting
// while the job queue is full. the back takes one at a time too: it reads the table,
// then compares and writes, holding while the response queue is full. reset sets the
// config registers to their defaults and clears the table's written flags; no clearing
// pass follows. two-entry queues sit between front and back and before the response
// ports, so a stalled response side holds the back while the front keeps dividing.
module grid_tile_event_throttle #(
   parameter int MAX_TILES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [gtet_pkg::POS_W-1:0]            req_pos_x,
   input  logic [gtet_pkg::POS_W-1:0]            req_pos_y,
   input  logic [gtet_pkg::TIME_W-1:0]           req_now_ms,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [gtet_pkg::TILE_OUT_W-1:0]       rsp_tile_index,
   output logic                                  rsp_log_event,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_we,
   input  logic [gtet_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gtet_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import gtet_pkg::*;

   localparam int JOB_W    = $bits(job_type);
   localparam int RESULT_W = $bits(result_type);
   localparam int QDEPTH   = 2;

   cfg_type             cfg_ff, cfg_in;
   logic [HOLD_W-1:0]   holdoff_ff, holdoff_in;
   csr_index_type       csr_sel;
   logic                job_push;
   logic                job_full;
   logic                job_empty;
   logic                job_pop;
   job_type             job_wr;
   job_type             job_rd;
   logic [JOB_W-1:0]    job_rd_bits;
   logic                result_push;
   logic                result_full;
   result_type          result_wr;
   result_type          result_rd;
   logic [RESULT_W-1:0] result_rd_bits;

   assign csr_sel = csr_index_type'(csr_index);

   // configuration registers
   always_comb begin
      cfg_in     = cfg_ff;
      holdoff_in = holdoff_ff;
      if (csr_we) begin
         unique case (csr_sel)
            CSR_TILE_SIZE:    cfg_in.tile_size    = csr_wdata[SIZE_W-1:0];
            CSR_GRID_DIM:     cfg_in.grid_dim     = csr_wdata[DIM_W-1:0];
            CSR_ACTIVE_TILES: cfg_in.active_tiles = csr_wdata[ACTIVE_W-1:0];
            CSR_HOLDOFF_MS:   holdoff_in          = csr_wdata[HOLD_W-1:0];
            default:          holdoff_in          = holdoff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_size    <= SIZE_W'(1);
         cfg_ff.grid_dim     <= DIM_W'(1);
         cfg_ff.active_tiles <= ACTIVE_W'(1);
         holdoff_ff          <= '0;
      end else begin
         cfg_ff     <= cfg_in;
         holdoff_ff <= holdoff_in;
      end
   end

   // front: divide and classify
   gtet_front #(
      .MAX_TILES (MAX_TILES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .now_ms   (req_now_ms),
      .cfg      (cfg_ff),
      .job_push (job_push),
      .job_full (job_full),
      .job      (job_wr)
   );

   // queue between front and back
   gtet_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (QDEPTH)
   ) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .full  (job_full),
      .wdata (job_wr),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (job_rd_bits)
   );

   assign job_rd = job_type'(job_rd_bits);

   // back: table lookup and holdoff decision
   gtet_back #(
      .MAX_TILES (MAX_TILES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .job         (job_rd),
      .holdoff_ms  (holdoff_ff),
      .result_push (result_push),
      .result_full (result_full),
      .result      (result_wr)
   );

   // response queue
   gtet_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (QDEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (result_push),
      .full  (result_full),
      .wdata (result_wr),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (result_rd_bits)
   );

   assign result_rd        = result_type'(result_rd_bits);
   assign rsp_tile_index   = result_rd.tile_index;
   assign rsp_log_event    = result_rd.log_event;
   assign rsp_out_of_range = result_rd.out_of_range;

endmodule
